[sv/itoa_pkg.sv]
package itoa_pkg;

    localparam int DEF_VALUE_BITS = 64;
    localparam int DEF_MAX_RADIX  = 36;

    localparam int VALUE_W = 64;
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] MIN_RADIX = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 6'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;

    // Map a digit value to its character: 0..9 then lower-case letters.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_MAX) begin
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end else begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

[sv/int64_to_ascii_radix_unit.sv]
// Integer to ASCII converter, any radix from 2 to MAX_RADIX.
// Input channel (i_valid / o_ready) takes one item: a value, a radix and a
// signed-mode flag. Output channel (o_valid / i_ready) returns the value's
// characters, most significant first, one per item, o_last high on the final
// one. Decimal output of a negative value in signed mode starts with '-'.
// Radix values out of range saturate to the nearest bound.
// Front: mask, saturate, negate and push into a two-entry queue, so the
// input keeps taking items while the back converts an earlier one.
// Back: restoring division by the radix, one quotient bit per cycle; the
// digits go into a buffer memory and are read out in reverse order, after
// the '-' if there is one.
// First character appears once all digits are produced.
// Reset clears the queue, the sequencer and the output valid; nothing else
// needs clearing. When the receiver stalls, hold the current character in
// the output register; the back stops, the queue fills, then o_ready drops.
module int64_to_ascii_radix_unit #(
    parameter int VALUE_BITS = itoa_pkg::DEF_VALUE_BITS,
    parameter int MAX_RADIX  = itoa_pkg::DEF_MAX_RADIX
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [itoa_pkg::VALUE_W-1:0]  i_value,
    input  logic [itoa_pkg::RADIX_W-1:0]  i_radix,
    input  logic                          i_signed_mode,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [itoa_pkg::CHAR_W-1:0]   o_ascii_char,
    output logic                          o_last
);

    // Job word: sign flag, saturated radix, magnitude.
    localparam int JOB_W = VALUE_BITS + itoa_pkg::RADIX_W + 1;

    logic             w_push;
    logic             w_full;
    logic             w_pop;
    logic             w_empty;
    logic [JOB_W-1:0] w_job_in;
    logic [JOB_W-1:0] w_job_out;

    itoa_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_RADIX  (MAX_RADIX),
        .JOB_W      (JOB_W)
    ) u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .i_radix       (i_radix),
        .i_signed_mode (i_signed_mode),
        .o_push        (w_push),
        .i_full        (w_full),
        .o_job         (w_job_in)
    );

    // Hold up to two classified items between front and back.
    itoa_queue #(
        .JOB_W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_job_out)
    );

    itoa_back #(
        .VALUE_BITS (VALUE_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_job        (w_job_out),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

endmodule

[sv/itoa_front.sv]
module itoa_front #(
    parameter int VALUE_BITS = itoa_pkg::DEF_VALUE_BITS,
    parameter int MAX_RADIX  = itoa_pkg::DEF_MAX_RADIX,
    parameter int JOB_W      = VALUE_BITS + itoa_pkg::RADIX_W + 1
) (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [itoa_pkg::VALUE_W-1:0]  i_value,
    input  logic [itoa_pkg::RADIX_W-1:0]  i_radix,
    input  logic                          i_signed_mode,
    output logic                          o_push,
    input  logic                          i_full,
    output logic [JOB_W-1:0]              o_job
);

    logic [VALUE_BITS-1:0]        w_val;
    logic [VALUE_BITS-1:0]        w_mag;
    logic [itoa_pkg::RADIX_W-1:0] w_radix;
    logic                         w_neg;

    always_comb begin
        w_val = i_value[VALUE_BITS-1:0];
        // Saturate the radix into the legal range.
        if (i_radix < itoa_pkg::MIN_RADIX) begin
            w_radix = itoa_pkg::MIN_RADIX;
        end else if (i_radix > itoa_pkg::RADIX_W'(MAX_RADIX)) begin
            w_radix = itoa_pkg::RADIX_W'(MAX_RADIX);
        end else begin
            w_radix = i_radix;
        end
        // Only decimal output carries a sign.
        w_neg = i_signed_mode && (w_radix == itoa_pkg::RADIX_DEC) && w_val[VALUE_BITS-1];
        w_mag = w_neg ? (~w_val + VALUE_BITS'(1)) : w_val;
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_job   = {w_neg, w_radix, w_mag};

endmodule

[sv/itoa_queue.sv]
module itoa_queue #(
    parameter int JOB_W = 71
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [JOB_W-1:0] i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [JOB_W-1:0] o_job
);

    logic [JOB_W-1:0] r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[sv/itoa_back.sv]
module itoa_back #(
    parameter int VALUE_BITS = itoa_pkg::DEF_VALUE_BITS,
    parameter int JOB_W      = VALUE_BITS + itoa_pkg::RADIX_W + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  logic [JOB_W-1:0]             i_job,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [itoa_pkg::CHAR_W-1:0]  o_ascii_char,
    output logic                         o_last
);

    localparam int IDX_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DW    = itoa_pkg::DIGIT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state                       r_state;
    logic [VALUE_BITS-1:0]        r_quot;
    logic [DW-1:0]                r_rem;
    logic [itoa_pkg::RADIX_W-1:0] r_radix;
    logic                         r_neg;
    logic [IDX_W-1:0]             r_bit;
    logic [CNT_W-1:0]             r_count;
    logic [IDX_W-1:0]             r_idx;
    logic                         r_oval;
    logic [itoa_pkg::CHAR_W-1:0]  r_char;
    logic                         r_last;

    logic [DW-1:0]                r_buf [VALUE_BITS];
    logic [DW-1:0]                r_rd;

    logic [DW:0]                  w_trial;
    logic                         w_ge;
    logic [DW-1:0]                n_rem;
    logic [VALUE_BITS-1:0]        n_quot;
    logic [CNT_W-1:0]             n_count;
    logic                         w_digit_done;
    logic                         w_out_free;
    logic                         w_char_load;

    // One quotient bit per cycle: restoring division by the radix.
    always_comb begin
        w_trial      = {r_rem, r_quot[VALUE_BITS-1]};
        w_ge         = (w_trial >= {1'b0, r_radix});
        n_rem        = w_ge ? DW'(w_trial - {1'b0, r_radix}) : DW'(w_trial);
        n_quot       = {r_quot[VALUE_BITS-2:0], w_ge};
        n_count      = r_count + CNT_W'(1);
        w_digit_done = (r_state == S_DIV) && (r_bit == IDX_W'(VALUE_BITS - 1));
        w_out_free   = !r_oval || i_ready;
        w_char_load  = w_out_free && ((r_state == S_SIGN) || (r_state == S_EMIT));
    end

    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign o_valid      = r_oval;
    assign o_ascii_char = r_char;
    assign o_last       = r_last;

    always_ff @(posedge i_clk) begin
        if (w_digit_done) begin
            r_buf[r_count[IDX_W-1:0]] <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_buf[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_bit   <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_neg   <= 1'b0;
        end else begin
            if (i_ready && !w_char_load) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_quot  <= i_job[VALUE_BITS-1:0];
                        r_radix <= i_job[VALUE_BITS +: itoa_pkg::RADIX_W];
                        r_neg   <= i_job[JOB_W-1];
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_count <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_quot <= n_quot;
                    if (w_digit_done) begin
                        r_count <= n_count;
                        r_rem   <= '0;
                        r_bit   <= '0;
                        if ((n_quot == '0) || (n_count == CNT_W'(VALUE_BITS))) begin
                            r_idx   <= r_count[IDX_W-1:0];
                            r_state <= r_neg ? S_SIGN : S_WAIT;
                        end
                    end else begin
                        r_rem <= n_rem;
                        r_bit <= r_bit + IDX_W'(1);
                    end
                end
                S_SIGN: begin
                    if (w_out_free) begin
                        r_oval  <= 1'b1;
                        r_char  <= itoa_pkg::CHAR_MINUS;
                        r_last  <= 1'b0;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_oval <= 1'b1;
                        r_char <= itoa_pkg::digit_to_ascii(r_rd);
                        r_last <= (r_idx == '0);
                        if (r_idx == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx - IDX_W'(1);
                            r_state <= S_WAIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[bench/int64_to_ascii_radix_unit_tb.sv]
`timescale 1ns / 1ps

module int64_to_ascii_radix_unit_tb;

    // Widths and codes shared with the block.
    localparam int VALUE_W       = itoa_pkg::VALUE_W;
    localparam int RADIX_W       = itoa_pkg::RADIX_W;
    localparam int DIGIT_W       = itoa_pkg::DIGIT_W;
    localparam int CHAR_W        = itoa_pkg::CHAR_W;
    localparam int DEF_MAX_RADIX = itoa_pkg::DEF_MAX_RADIX;

    localparam logic [RADIX_W-1:0] MIN_RADIX  = itoa_pkg::MIN_RADIX;
    localparam logic [RADIX_W-1:0] RADIX_DEC  = itoa_pkg::RADIX_DEC;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = itoa_pkg::DIGIT_MAX;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = itoa_pkg::DIGIT_TEN;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = itoa_pkg::CHAR_MINUS;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = itoa_pkg::CHAR_ZERO;
    localparam logic [CHAR_W-1:0]  CHAR_A     = itoa_pkg::CHAR_A;

    // Run bounds. The limit covers the slowest legal run several times over:
    // every value as 64 binary digits, every character behind a receiver stall,
    // the long hold-off and the tail.
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int TAIL_CYCLES  = 300;
    localparam int MAX_DIGITS   = 64;
    localparam int MAX_PRINTS   = 40;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    // One expected output character and its end-of-value flag.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_ascii_due;

    // Block inputs, all known from time zero.
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic [VALUE_W-1:0]   i_value       = '0;
    logic [RADIX_W-1:0]   i_radix       = RADIX_DEC;
    logic                 i_signed_mode = 1'b0;
    logic                 i_ready       = 1'b0;

    // Block outputs.
    logic                 o_ready;
    logic                 o_valid;
    logic [CHAR_W-1:0]    o_ascii_char;
    logic                 o_last;

    // Characters still owed by the block, oldest first.
    t_ascii_due ascii_due[$];

    // Idling knobs, in percent of cycles.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Hold-off handshake between the stimulus and the receiver process.
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    // Bookkeeping.
    int err_cnt           = 0;
    int cycle_cnt         = 0;
    int values_taken      = 0;
    int chars_checked     = 0;
    int minus_values      = 0;
    int full_width_values = 0;

    int64_to_ascii_radix_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .i_radix       (i_radix),
        .i_signed_mode (i_signed_mode),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_ascii_char  (o_ascii_char),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: end the run if the block stops making progress.
    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    // Print one line per mismatch (capped) and count it.
    task automatic report_mismatch(input string what);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Work out the characters of one accepted value and queue them.
    // Saturate the radix, negate only for signed decimal with the top bit
    // set, then divide repeatedly; digits come out least significant first
    // so emit them in reverse.
    function automatic void predict_ascii_digits(input logic [VALUE_W-1:0] value,
                                                 input logic [RADIX_W-1:0] radix_in,
                                                 input logic sgn);
        logic [VALUE_W-1:0] quot;
        logic [6:0]         base;
        logic [DIGIT_W-1:0] digits[MAX_DIGITS];
        logic [DIGIT_W-1:0] d;
        t_ascii_due         due;
        int                 n;
        bit                 minus;

        base = {1'b0, radix_in};
        if (base < MIN_RADIX) begin
            base = MIN_RADIX;
        end
        if (base > DEF_MAX_RADIX) begin
            base = 7'(DEF_MAX_RADIX);
        end

        quot  = value;
        minus = sgn && (base == RADIX_DEC) && quot[VALUE_W-1];
        if (minus) begin
            // The most negative value wraps to itself and reads as unsigned.
            quot = '0 - quot;
            due.ch   = CHAR_MINUS;
            due.last = 1'b0;
            ascii_due.push_back(due);
            minus_values++;
        end

        n = 0;
        do begin
            digits[n] = DIGIT_W'(quot % base);
            quot      = quot / base;
            n++;
        end while (quot != 0 && n < MAX_DIGITS);
        if (n == MAX_DIGITS) begin
            full_width_values++;
        end

        for (int k = n - 1; k >= 0; k--) begin
            d = digits[k];
            if (d > DIGIT_MAX) begin
                due.ch = CHAR_A + CHAR_W'(d - DIGIT_TEN);
            end else begin
                due.ch = CHAR_ZERO + CHAR_W'(d);
            end
            due.last = (k == 0);
            ascii_due.push_back(due);
        end
    endfunction

    // Monitor both channels at each edge: predict on input accept,
    // compare on output accept. Sampled values are those before the edge.
    always @(posedge i_clk) begin
        t_ascii_due due;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_ascii_digits(i_value, i_radix, i_signed_mode);
                values_taken++;
            end
            if (o_valid && i_ready) begin
                chars_checked++;
                if (ascii_due.size() == 0) begin
                    report_mismatch($sformatf("char 0x%02h last %0b with nothing owed",
                                              o_ascii_char, o_last));
                end else begin
                    due = ascii_due.pop_front();
                    if (o_ascii_char !== due.ch) begin
                        report_mismatch($sformatf("char 0x%02h, wanted 0x%02h",
                                                  o_ascii_char, due.ch));
                    end
                    if (o_last !== due.last) begin
                        report_mismatch($sformatf("last %0b on char 0x%02h, wanted %0b",
                                                  o_last, due.ch, due.last));
                    end
                end
            end
        end
    end

    // Receiver: honour a requested hold-off first, otherwise stall at random.
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            IDLE_BOTH: begin send_idle_pct = 10; recv_stall_pct = 10; end
            default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Offer one item; idle first at random, then hold valid and the payload
    // until the block takes it. Returns at the accepting edge.
    task automatic send_number(input logic [VALUE_W-1:0] value,
                               input logic [RADIX_W-1:0] radix,
                               input logic sgn);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_value       <= value;
        i_radix       <= radix;
        i_signed_mode <= sgn;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and wait until every owed character has come out.
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (ascii_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_test_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(5))
            0:       v = VALUE_W'($urandom_range(40));
            1:       v = {32'h0, $urandom};
            2:       v = (64'd1 << $urandom_range(63)) - VALUE_W'($urandom_range(1));
            3:       v = {1'b1, 31'($urandom), $urandom};
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Favour decimal so the sign path is hit often; keep some out-of-range.
    function automatic logic [RADIX_W-1:0] pick_radix();
        logic [RADIX_W-1:0] r;
        case ($urandom_range(7))
            0, 1:    r = RADIX_W'($urandom_range(63));
            2, 3:    r = RADIX_DEC;
            default: r = RADIX_W'($urandom_range(2, DEF_MAX_RADIX));
        endcase
        return r;
    endfunction

    // Edges of the value range, saturating radixes, sign handling and zero.
    task automatic test_directed_edges();
        set_idle_mode(IDLE_NONE);
        send_number(64'd0,                   RADIX_DEC, 1'b0);
        send_number(64'd0,                   6'd2,      1'b1);
        send_number(64'd9,                   RADIX_DEC, 1'b0);
        send_number(64'd10,                  6'd11,     1'b0);
        send_number(64'd35,                  6'd36,     1'b0);
        send_number('1,                      6'd2,      1'b0);
        send_number('1,                      RADIX_DEC, 1'b0);
        send_number('1,                      RADIX_DEC, 1'b1);
        send_number('1,                      6'd16,     1'b1);
        send_number('1,                      6'd36,     1'b0);
        send_number(64'h8000_0000_0000_0000, RADIX_DEC, 1'b1);
        send_number(64'h8000_0000_0000_0000, RADIX_DEC, 1'b0);
        send_number(64'h8000_0000_0000_0000, 6'd16,     1'b1);
        send_number(64'h7fff_ffff_ffff_ffff, RADIX_DEC, 1'b1);
        send_number(64'd123,                 RADIX_DEC, 1'b1);
        send_number(64'h0123_4567_89ab_cdef, 6'd16,     1'b0);
        send_number(64'd255,                 6'd0,      1'b0);
        send_number(64'd5,                   6'd1,      1'b1);
        send_number(64'd1295,                6'd37,     1'b0);
        send_number(64'hdead_beef_0bad_cafe, 6'd63,     1'b1);
        wait_results_drained();
    endtask

    // Random values and radixes under one idling mix.
    task automatic test_random_mix(input t_idle_mode mode, input int count);
        set_idle_mode(mode);
        repeat (count) begin
            send_number(pick_test_value(), pick_radix(), 1'($urandom_range(1)));
        end
        wait_results_drained();
    endtask

    // Hold the receiver off while the sender keeps offering short values,
    // so the block fills and drops o_ready; then pause until all is out.
    task automatic test_output_hold();
        set_idle_mode(IDLE_NONE);
        hold_req++;
        repeat (8) begin
            send_number(VALUE_W'($urandom_range(1295)), 6'd36, 1'($urandom_range(1)));
        end
        wait_results_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_random_mix(IDLE_NONE, 30);
        test_random_mix(IDLE_SEND, 30);
        test_random_mix(IDLE_RECV, 30);
        test_random_mix(IDLE_BOTH, 30);
        test_output_hold();

        // Let any stray character show itself before closing.
        set_idle_mode(IDLE_NONE);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d values (%0d with a minus sign, %0d at 64 binary digits), %0d chars.",
                 values_taken, minus_values, full_width_values, chars_checked);
        $display("Idle mixes, saturated radixes, long receiver hold-off; %0d mismatches.",
                 err_cnt);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
